@@ design/htd_pkg.sv @@
// Package for the Huffman tree decoder: sizes, action, status and command codes,
// the status type that the controller and the datapath share, and the datapath's node record.
// It depends on nothing else.
package htd_pkg;

    // Sizes of the node store and of the code path.
    localparam int NODE_COUNT    = 512;
    localparam int MAX_CODE_BITS = 32;
    localparam int SYMBOL_COUNT  = 256;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int USED_W  = $clog2(NODE_COUNT + 1);
    localparam int CNT_W   = $clog2(MAX_CODE_BITS + 1);
    localparam int SYM_W   = 8;
    localparam int LEN_W   = 6;
    localparam int CODE_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int PAD_W   = 4;
    localparam int ACT_W   = 2;
    localparam int ST_W    = 2;
    localparam int SHIFT_W = 2 ** LEN_W;

    // Actions carried by an input item.
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DECODE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_SYMBOL  = 2'd0;
    localparam logic [ST_W-1:0] ST_DONE    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

    // Commands from the controller to the datapath.
    typedef logic [3:0] t_cmd;
    localparam t_cmd CMD_NOP      = 4'd0;
    localparam t_cmd CMD_INIT     = 4'd1;
    localparam t_cmd CMD_CLEAR    = 4'd2;
    localparam t_cmd CMD_INS_LOAD = 4'd3;
    localparam t_cmd CMD_INS_RD   = 4'd4;
    localparam t_cmd CMD_INS_EV   = 4'd5;
    localparam t_cmd CMD_INS_FR   = 4'd6;
    localparam t_cmd CMD_DEC_LOAD = 4'd7;
    localparam t_cmd CMD_DEC_RD   = 4'd8;
    localparam t_cmd CMD_DEC_ST   = 4'd9;
    localparam t_cmd CMD_FLUSH    = 4'd10;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ins_skip;    // the insert at the inputs changes nothing
        logic bits_empty;  // no code or data bits are left to walk
        logic child_hit;   // the current node has the child that the next bit selects
        logic store_full;  // every node of the store is in use
    } t_sts;

    // One entry of the node store.
    typedef struct packed {
        logic              leaf;
        logic [SYM_W-1:0]  sym;
        logic [1:0]        cv;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } t_node;

    localparam int REC_W = 1 + SYM_W + 2 + 2 * NODE_W;

endpackage

@@ design/htd_ctrl.sv @@
// Controller of the Huffman tree decoder: sequences clear, insert and decode steps.
// Depends on htd_pkg; drives the datapath by command codes and reads its status.
module htd_ctrl
    import htd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACT_W-1:0] i_action,
    input  t_sts             i_sts,
    output logic             o_busy,
    output t_cmd             o_cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_INS_RD = 3'd2;
    localparam logic [2:0] S_INS_EV = 3'd3;
    localparam logic [2:0] S_INS_FR = 3'd4;
    localparam logic [2:0] S_DEC_RD = 3'd5;
    localparam logic [2:0] S_DEC_ST = 3'd6;
    localparam logic [2:0] S_FLUSH  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        case (r_state)
            S_INIT: begin
                o_cmd   = CMD_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        ACT_CLEAR: begin
                            o_cmd   = CMD_CLEAR;
                            n_state = S_FLUSH;
                        end
                        ACT_INSERT: begin
                            o_cmd   = CMD_INS_LOAD;
                            n_state = i_sts.ins_skip ? S_FLUSH : S_INS_RD;
                        end
                        ACT_DECODE: begin
                            o_cmd   = CMD_DEC_LOAD;
                            n_state = S_DEC_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                o_cmd   = CMD_INS_RD;
                n_state = S_INS_EV;
            end
            S_INS_EV: begin
                o_cmd = CMD_INS_EV;
                if (i_sts.bits_empty) begin
                    n_state = S_FLUSH;
                end else if (i_sts.child_hit) begin
                    n_state = S_INS_RD;
                end else if (i_sts.store_full) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_INS_FR;
                end
            end
            S_INS_FR: begin
                o_cmd   = CMD_INS_FR;
                n_state = S_INS_RD;
            end
            S_DEC_RD: begin
                o_cmd   = CMD_DEC_RD;
                n_state = S_DEC_ST;
            end
            S_DEC_ST: begin
                o_cmd = CMD_DEC_ST;
                if (i_sts.bits_empty) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd   = CMD_FLUSH;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ design/htd_datapath.sv @@
// Datapath of the Huffman tree decoder: node store, walk registers and result buffer.
// Depends on htd_pkg; it acts on the command codes of htd_ctrl.
module htd_datapath
    import htd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [SYM_W-1:0]  i_code_symbol,
    input  logic [LEN_W-1:0]  i_code_length,
    input  logic [CODE_W-1:0] i_code_value,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_final_byte,
    input  logic [PAD_W-1:0]  i_pad_bits,
    output t_sts              o_sts,
    output logic              o_valid,
    output logic [SYM_W-1:0]  o_symbol,
    output logic [ST_W-1:0]   o_status,
    output logic              o_last_of_run
);

    // Node store: one write and one registered read per cycle.
    logic [REC_W-1:0]  r_mem [NODE_COUNT];
    logic [REC_W-1:0]  r_rdata;
    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    logic [REC_W-1:0]  mem_wdata;
    logic [NODE_W-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    logic [NODE_W-1:0]  r_node, n_node;
    logic [NODE_W-1:0]  r_walk, n_walk;
    logic [USED_W-1:0]  r_used, n_used;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]   r_bits, n_bits;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_final, n_final;
    logic               r_chk, n_chk;
    logic               r_pend_valid, n_pend_valid;
    logic [SYM_W-1:0]   r_pend_sym, n_pend_sym;
    logic [ST_W-1:0]    r_pend_st, n_pend_st;
    logic               r_out_valid, n_out_valid;
    logic [SYM_W-1:0]   r_out_sym, n_out_sym;
    logic [ST_W-1:0]    r_out_st, n_out_st;
    logic               r_out_last, n_out_last;

    t_node              rd;
    t_node              upd;
    logic               bit_now;
    logic [NODE_W-1:0]  child;
    logic               emit_en;
    logic [SYM_W-1:0]   emit_sym;
    logic [ST_W-1:0]    emit_st;
    logic [LEN_W:0]     shamt;

    assign rd      = t_node'(r_rdata);
    assign bit_now = r_shift[SHIFT_W-1];
    assign child   = bit_now ? rd.right : rd.left;
    assign shamt   = (LEN_W + 1)'(SHIFT_W) - {1'b0, i_code_length};

    assign o_sts.ins_skip   = (i_code_length == '0)
                              || ({1'b0, i_code_symbol} >= (SYM_W + 1)'(SYMBOL_COUNT));
    assign o_sts.bits_empty = (r_bits == '0);
    assign o_sts.child_hit  = rd.cv[bit_now];
    assign o_sts.store_full = (r_used == USED_W'(NODE_COUNT));

    always_comb begin
        n_node       = r_node;
        n_walk       = r_walk;
        n_used       = r_used;
        n_shift      = r_shift;
        n_bits       = r_bits;
        n_sym        = r_sym;
        n_final      = r_final;
        n_chk        = r_chk;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_pend_st    = r_pend_st;
        n_out_valid  = 1'b0;
        n_out_sym    = r_out_sym;
        n_out_st     = r_out_st;
        n_out_last   = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_node;
        mem_wdata    = '0;
        mem_raddr    = r_node;
        emit_en      = 1'b0;
        emit_sym     = '0;
        emit_st      = ST_DONE;
        upd          = rd;

        case (i_cmd)
            CMD_INIT, CMD_CLEAR: begin
                // Root entry back to empty; all other nodes are out of use.
                mem_we    = 1'b1;
                mem_waddr = '0;
                n_used    = USED_W'(1);
                n_walk    = '0;
                if (i_cmd == CMD_CLEAR) begin
                    emit_en = 1'b1;
                end
            end
            CMD_INS_LOAD: begin
                n_sym = i_code_symbol;
                if (o_sts.ins_skip) begin
                    emit_en = 1'b1;
                end else begin
                    n_node  = '0;
                    // First code bit lands at the top of the shift register.
                    n_shift = SHIFT_W'(i_code_value) << shamt;
                    if ({1'b0, i_code_length} < (LEN_W + 1)'(MAX_CODE_BITS)) begin
                        n_bits = CNT_W'(i_code_length);
                    end else begin
                        n_bits = CNT_W'(MAX_CODE_BITS);
                    end
                end
            end
            CMD_INS_EV: begin
                if (o_sts.bits_empty) begin
                    upd.leaf  = 1'b1;
                    upd.sym   = r_sym;
                    mem_we    = 1'b1;
                    mem_wdata = REC_W'(upd);
                    emit_en   = 1'b1;
                end else if (o_sts.child_hit) begin
                    n_node  = child;
                    n_shift = {r_shift[SHIFT_W-2:0], 1'b0};
                    n_bits  = r_bits - CNT_W'(1);
                end else if (o_sts.store_full) begin
                    emit_en = 1'b1;
                    emit_st = ST_FULL;
                end else begin
                    // Hang the next free node below the current one.
                    if (bit_now) begin
                        upd.right = r_used[NODE_W-1:0];
                        upd.cv[1] = 1'b1;
                    end else begin
                        upd.left  = r_used[NODE_W-1:0];
                        upd.cv[0] = 1'b1;
                    end
                    mem_we    = 1'b1;
                    mem_wdata = REC_W'(upd);
                    n_node    = r_used[NODE_W-1:0];
                    n_used    = r_used + USED_W'(1);
                    n_shift   = {r_shift[SHIFT_W-2:0], 1'b0};
                    n_bits    = r_bits - CNT_W'(1);
                end
            end
            CMD_INS_FR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            CMD_DEC_LOAD: begin
                n_final = i_final_byte;
                n_shift = {i_data_byte, (SHIFT_W - BYTE_W)'(0)};
                if (!i_final_byte) begin
                    n_bits = CNT_W'(BYTE_W);
                end else if (i_pad_bits >= PAD_W'(BYTE_W)) begin
                    n_bits = '0;
                end else begin
                    n_bits = CNT_W'(PAD_W'(BYTE_W) - i_pad_bits);
                end
            end
            CMD_DEC_RD: begin
                mem_raddr = r_walk;
                n_chk     = 1'b0;
            end
            CMD_DEC_ST: begin
                if (r_chk && rd.leaf) begin
                    // The node just entered is a leaf: emit and restart at the root.
                    emit_en   = 1'b1;
                    emit_sym  = rd.sym;
                    emit_st   = ST_SYMBOL;
                    n_walk    = '0;
                    mem_raddr = '0;
                    n_chk     = 1'b0;
                end else if (!o_sts.bits_empty) begin
                    n_shift = {r_shift[SHIFT_W-2:0], 1'b0};
                    n_bits  = r_bits - CNT_W'(1);
                    if (o_sts.child_hit) begin
                        n_walk    = child;
                        mem_raddr = child;
                        n_chk     = 1'b1;
                    end else begin
                        emit_en   = 1'b1;
                        emit_st   = ST_MISSING;
                        n_walk    = '0;
                        mem_raddr = '0;
                        n_chk     = 1'b0;
                    end
                end else begin
                    mem_raddr = r_walk;
                end
                if (o_sts.bits_empty && r_final) begin
                    n_walk = '0;
                end
            end
            CMD_FLUSH: begin
                if (r_pend_valid) begin
                    n_out_valid  = 1'b1;
                    n_out_sym    = r_pend_sym;
                    n_out_st     = r_pend_st;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
                n_chk = r_chk;
            end
        endcase

        // A new result pushes the held one out; the held one is the last only at flush.
        if (emit_en) begin
            n_out_valid  = r_pend_valid;
            n_out_sym    = r_pend_sym;
            n_out_st     = r_pend_st;
            n_out_last   = 1'b0;
            n_pend_valid = 1'b1;
            n_pend_sym   = emit_sym;
            n_pend_st    = emit_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= USED_W'(1);
            r_walk       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_used       <= n_used;
            r_walk       <= n_walk;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node     <= n_node;
        r_shift    <= n_shift;
        r_bits     <= n_bits;
        r_sym      <= n_sym;
        r_final    <= n_final;
        r_chk      <= n_chk;
        r_pend_sym <= n_pend_sym;
        r_pend_st  <= n_pend_st;
        r_out_sym  <= n_out_sym;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_symbol      = r_out_sym;
    assign o_status      = r_out_st;
    assign o_last_of_run = r_out_last;

endmodule

@@ design/huffman_tree_decoder_top.sv @@
// Huffman tree decoder, one item at a time; results are never stalled. Busy stays high
// through the flush state for a clear or a skipped insert; an insert reads and evaluates each
// path node and writes each new one, and a decode reads the walk node and steps per decoded
// bit and per symbol, all ending in the flush; the unused action is dropped. The last result
// strobes in the first idle cycle, when the next item may already be taken. Synchronous
// active-low reset: busy stays high after it while the root entry is cleared.
module huffman_tree_decoder_top
    import htd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [SYM_W-1:0]  i_code_symbol,
    input  logic [LEN_W-1:0]  i_code_length,
    input  logic [CODE_W-1:0] i_code_value,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_final_byte,
    input  logic [PAD_W-1:0]  i_pad_bits,
    output logic              o_valid,
    output logic [SYM_W-1:0]  o_symbol,
    output logic [ST_W-1:0]   o_status,
    output logic              o_last_of_run
);

    // The controller decides the sequence of steps for each item; the datapath owns
    // the node store and all registers that carry tree and walk data.
    t_cmd cmd;
    t_sts sts;

    htd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // Nodes are handed out in order, so an entry is written with an empty record at
    // the moment it joins the tree. Entries past the fill count are never reached,
    // which is why the store needs no clearing sweep beyond the root entry.
    // Results are held back by one so that the final one can carry last_of_run.
    htd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_code_symbol (i_code_symbol),
        .i_code_length (i_code_length),
        .i_code_value  (i_code_value),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .i_pad_bits    (i_pad_bits),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_symbol      (o_symbol),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

`ifndef ASSERT_OFF
    // The last result of an item is never directly followed by another result.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_run |=> !o_valid)
        else $error("result directly after the last result of an item");

    // Clear and insert give exactly one result each.
    a_table_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DONE || o_status == ST_FULL) |-> o_last_of_run)
        else $error("table result not marked as last");

    // Status-only results carry a zero symbol.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_SYMBOL |-> o_symbol == '0)
        else $error("status result with nonzero symbol");

    // An accepted item with a real action keeps the block busy in the next cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_action != ACT_NONE |=> busy)
        else $error("block not busy after taking an item");
`endif

endmodule

@@ tb/huffman_tree_decoder_checker.sv @@
// Checker for the Huffman tree decoder: watches the item and result channels, keeps
// its own copy of the code tree and compares every result with the oldest one expected.
// Depends on htd_pkg for sizes, action codes and status codes.
module huffman_tree_decoder_checker
    import htd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [SYM_W-1:0]  i_code_symbol,
    input  logic [LEN_W-1:0]  i_code_length,
    input  logic [CODE_W-1:0] i_code_value,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_final_byte,
    input  logic [PAD_W-1:0]  i_pad_bits,
    input  logic              i_valid,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [ST_W-1:0]   i_status,
    input  logic              i_last_of_run,
    output int                o_mismatches,
    output int                o_pending
);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [ST_W-1:0]  status;
        logic             last_of_run;
    } t_tree_result;

    // Shadow copy of the code tree; bit 0 of kid_valid marks the left child.
    logic [NODE_W-1:0] left_kid  [NODE_COUNT];
    logic [NODE_W-1:0] right_kid [NODE_COUNT];
    logic [1:0]        kid_valid [NODE_COUNT];
    logic              is_leaf   [NODE_COUNT];
    logic [SYM_W-1:0]  leaf_sym  [NODE_COUNT];
    int                nodes_used;
    int                walk_node;

    t_tree_result      tree_results_q[$];
    t_tree_result      item_results[8];
    int                item_count;
    int                mismatch_count = 0;

    task tree_clear();
        for (int n = 0; n < NODE_COUNT; n++) begin
            left_kid[n]  = '0;
            right_kid[n] = '0;
            kid_valid[n] = 2'b00;
            is_leaf[n]   = 1'b0;
        end
        nodes_used = 1;
        walk_node  = 0;
    endtask

    task add_result(input logic [SYM_W-1:0] sym, input logic [ST_W-1:0] st);
        item_results[item_count] = '{sym, st, 1'b0};
        item_count++;
    endtask

    task report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("%0t checker: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_tree_result     got;
        t_tree_result     want;
        logic [ST_W-1:0]  ins_status;
        logic             b;
        int               n;
        int               pos;
        int               node;
        int               nxt;
        int               stop;
        if (!i_rst_n) begin
            tree_clear();
            for (int k = 0; k < NODE_COUNT; k++)
                leaf_sym[k] = '0;
            tree_results_q.delete();
        end else begin
            // A result seen at this edge always belongs to an earlier item.
            if (i_valid) begin
                got = '{i_symbol, i_status, i_last_of_run};
                if (tree_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sym %h status %0d last %0d",
                                              got.symbol, got.status, got.last_of_run));
                end else begin
                    want = tree_results_q.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "got sym %h status %0d last %0d, wanted sym %h status %0d last %0d",
                            got.symbol, got.status, got.last_of_run,
                            want.symbol, want.status, want.last_of_run));
                end
            end

            if (i_start && !i_busy) begin
                item_count = 0;
                case (i_action)
                    ACT_CLEAR: begin
                        tree_clear();
                        add_result('0, ST_DONE);
                    end
                    ACT_INSERT: begin
                        ins_status = ST_DONE;
                        if (i_code_length != 0 && int'(i_code_symbol) < SYMBOL_COUNT) begin
                            n = (int'(i_code_length) < MAX_CODE_BITS) ?
                                int'(i_code_length) : MAX_CODE_BITS;
                            node = 0;
                            for (int j = 0; j < n && ins_status == ST_DONE; j++) begin
                                pos = int'(i_code_length) - 1 - j;
                                b = (pos < CODE_W) ? i_code_value[pos] : 1'b0;
                                if (!kid_valid[node][b]) begin
                                    if (nodes_used >= NODE_COUNT) begin
                                        ins_status = ST_FULL;
                                    end else begin
                                        if (b)
                                            right_kid[node] = NODE_W'(nodes_used);
                                        else
                                            left_kid[node] = NODE_W'(nodes_used);
                                        kid_valid[node][b] = 1'b1;
                                        nodes_used++;
                                    end
                                end
                                if (ins_status == ST_DONE)
                                    node = b ? int'(right_kid[node]) : int'(left_kid[node]);
                            end
                            if (ins_status == ST_DONE) begin
                                is_leaf[node]  = 1'b1;
                                leaf_sym[node] = i_code_symbol;
                            end
                        end
                        add_result('0, ins_status);
                    end
                    ACT_DECODE: begin
                        stop = 0;
                        if (i_final_byte)
                            stop = (i_pad_bits > 8) ? 8 : int'(i_pad_bits);
                        for (int i = 7; i >= stop; i--) begin
                            b = i_data_byte[i];
                            if (!kid_valid[walk_node][b]) begin
                                add_result('0, ST_MISSING);
                                walk_node = 0;
                            end else begin
                                nxt = b ? int'(right_kid[walk_node]) : int'(left_kid[walk_node]);
                                if (is_leaf[nxt]) begin
                                    add_result(leaf_sym[nxt], ST_SYMBOL);
                                    walk_node = 0;
                                end else begin
                                    walk_node = nxt;
                                end
                            end
                        end
                        if (i_final_byte)
                            walk_node = 0;
                    end
                    default: begin
                    end
                endcase
                for (int k = 0; k < item_count; k++) begin
                    item_results[k].last_of_run = (k == item_count - 1);
                    tree_results_q.push_back(item_results[k]);
                end
            end
        end
        o_pending    <= tree_results_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ tb/tb_huffman_tree_decoder_top.sv @@
// Testbench top for the Huffman tree decoder: directed items, then random code sets
// with encoded streams, store-filling runs and noise, under several sender idle plans.
// Depends on htd_pkg, huffman_tree_decoder_top and huffman_tree_decoder_checker.
module tb_huffman_tree_decoder_top;
    import htd_pkg::*;

    // The slowest item is an insert of a 32-bit code, which adds a node per bit, plus
    // the longest sender gap; a few hundred items fit well inside this limit.
    localparam int CYCLE_LIMIT  = 200000;
    // A decode byte that yields nothing can still be running after the last result.
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 310;
    localparam int PHASE_ITEMS  = 80;
    // Percent of items after which the sender goes idle, one entry per phase.
    // The third phase stands for receiver stalls, which this block does not allow,
    // so it runs at full rate like the first.
    localparam int IDLE_PLAN [4] = '{0, 64, 0, 29};

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic              busy;
    logic [ACT_W-1:0]  i_action      = ACT_NONE;
    logic [SYM_W-1:0]  i_code_symbol = '0;
    logic [LEN_W-1:0]  i_code_length = '0;
    logic [CODE_W-1:0] i_code_value  = '0;
    logic [BYTE_W-1:0] i_data_byte   = '0;
    logic              i_final_byte  = 1'b0;
    logic [PAD_W-1:0]  i_pad_bits    = '0;
    logic              o_valid;
    logic [SYM_W-1:0]  o_symbol;
    logic [ST_W-1:0]   o_status;
    logic              o_last_of_run;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int items_sent  = 0;
    int idle_pct    = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    huffman_tree_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_code_symbol (i_code_symbol),
        .i_code_length (i_code_length),
        .i_code_value  (i_code_value),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .i_pad_bits    (i_pad_bits),
        .o_valid       (o_valid),
        .o_symbol      (o_symbol),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    huffman_tree_decoder_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_action      (i_action),
        .i_code_symbol (i_code_symbol),
        .i_code_length (i_code_length),
        .i_code_value  (i_code_value),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .i_pad_bits    (i_pad_bits),
        .i_valid       (o_valid),
        .i_symbol      (o_symbol),
        .i_status      (o_status),
        .i_last_of_run (o_last_of_run),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Watchdog: a hung handshake or a result that never comes ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Presents one item and returns at the edge that accepts it. It is always called
    // at a rising edge. Start stays high when no gap follows, so back-to-back items
    // never lower and raise it within one time step. After acceptance the sender may
    // go idle for a random stretch, which lands the next item on any cycle of the
    // block's work.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                             input logic [BYTE_W-1:0] data, input logic fin,
                             input logic [PAD_W-1:0] pad);
        start         <= 1'b1;
        i_action      <= act;
        i_code_symbol <= sym;
        i_code_length <= len;
        i_code_value  <= code;
        i_data_byte   <= data;
        i_final_byte  <= fin;
        i_pad_bits    <= pad;
        // Busy is read right after the edge, so it still holds its value from
        // before the edge, which is what the block used to take the item.
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (act != ACT_NONE)
            items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    endtask

    // Fields that an action does not use get random values so that every bit moves.
    task automatic send_clear();
        send_item(ACT_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom),
                  1'($urandom), 4'($urandom));
    endtask

    task automatic send_insert(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                               input logic [CODE_W-1:0] code);
        send_item(ACT_INSERT, sym, len, code, 8'($urandom), 1'($urandom), 4'($urandom));
    endtask

    task automatic send_decode(input logic [BYTE_W-1:0] data, input logic fin,
                               input logic [PAD_W-1:0] pad);
        send_item(ACT_DECODE, 8'($urandom), 6'($urandom), $urandom, data, fin, pad);
    endtask

    // Holds the sender off until every expected result has arrived. The first edge
    // lets the checker's pending count catch up with the item just accepted.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Builds a random complete prefix code by splitting leaves, loads it into a fresh
    // tree and then decodes a random message encoded with it. The last byte carries
    // the real pad count; now and then it is not marked final, so the walk carries
    // over into the next stream, and a stray byte is slipped in to break the stream.
    task automatic run_code_stream();
        int          cw_len [64];
        logic [31:0] cw_val [64];
        int          cw_count;
        int          leaves;
        int          depth_cap;
        int          k;
        int          s;
        int          n_sym;
        int          nbytes;
        logic [7:0]  sym_base;
        logic [7:0]  sym_step;
        logic [7:0]  byte_val;
        bit          stream_bits[$];
        send_clear();
        leaves    = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(2, 16);
        depth_cap = ($urandom_range(4) == 0) ? MAX_CODE_BITS : 12;
        cw_count  = 1;
        cw_len[0] = 0;
        cw_val[0] = '0;
        while (cw_count < leaves) begin
            k = $urandom_range(cw_count - 1);
            if (cw_len[k] < depth_cap) begin
                cw_len[cw_count] = cw_len[k] + 1;
                cw_val[cw_count] = {cw_val[k][30:0], 1'b1};
                cw_len[k]++;
                cw_val[k] = {cw_val[k][30:0], 1'b0};
                cw_count++;
            end
        end
        // An odd step keeps the symbols of one code set distinct.
        sym_base = 8'($urandom);
        sym_step = 8'($urandom) | 8'd1;
        for (k = 0; k < cw_count; k++)
            send_insert(sym_base + 8'(k) * sym_step, 6'(cw_len[k]), cw_val[k]);

        n_sym = $urandom_range(4, 30);
        for (k = 0; k < n_sym; k++) begin
            s = $urandom_range(cw_count - 1);
            for (int b = cw_len[s] - 1; b >= 0; b--)
                stream_bits.push_back(cw_val[s][b]);
        end
        nbytes = (stream_bits.size() + 7) / 8;
        for (k = 0; k < nbytes; k++) begin
            // Unused tail bits of the last byte keep random values.
            byte_val = 8'($urandom);
            for (int b = 0; b < 8; b++)
                if (k * 8 + b < stream_bits.size())
                    byte_val[7 - b] = stream_bits[k * 8 + b];
            if ($urandom_range(19) == 0)
                send_decode(8'($urandom), 1'b0, 4'($urandom));
            if (k == nbytes - 1)
                send_decode(byte_val, $urandom_range(99) < 85,
                            4'(nbytes * 8 - stream_bits.size()));
            else
                send_decode(byte_val, 1'b0, 4'($urandom));
        end
    endtask

    // Long random codes use up to 32 nodes each, so a couple of dozen of them run the
    // node store out; the decodes afterwards walk the deep, sparse paths.
    task automatic run_store_fill();
        send_clear();
        for (int k = 0; k < 24; k++)
            send_insert(8'($urandom),
                        $urandom_range(1) ? 6'(MAX_CODE_BITS) : 6'($urandom_range(33, 63)),
                        $urandom);
        for (int k = 0; k < 4; k++)
            send_decode(8'($urandom), 1'($urandom), 4'($urandom));
    endtask

    // Unstructured items of every kind on top of whatever tree is there.
    task automatic run_noise();
        int pick;
        int count;
        count = $urandom_range(5, 15);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_decode(8'($urandom), 1'($urandom), 4'($urandom));
            else if (pick < 80)
                send_insert(8'($urandom),
                            ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(1, 6)),
                            $urandom);
            else if (pick < 90)
                send_clear();
            else
                send_item(ACT_NONE, 8'($urandom), 6'($urandom), $urandom, 8'($urandom),
                          1'($urandom), 4'($urandom));
        end
    endtask

    initial begin : stimulus
        int phase;
        int pick;
        // Reset is held low at the start and released at a rising edge.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. An empty tree first: every bit of a byte hits a missing child.
        send_clear();
        send_decode(8'hA5, 1'b0, 4'd0);
        // A zero-length code changes nothing.
        send_insert(8'h3C, 6'd0, 32'hFFFF_FFFF);
        // Code set 0 -> 00, 10 -> FF, 11 -> 5A, covering both symbol extremes.
        send_insert(8'h00, 6'd1, 32'h0);
        send_insert(8'hFF, 6'd2, 32'h2);
        send_insert(8'h5A, 6'd2, 32'h3);
        send_decode(8'h00, 1'b1, 4'd0);
        send_decode(8'hFF, 1'b1, 4'd0);
        // A final byte with seven pad bits stops on an inner node and leaves nothing.
        send_decode(8'hB4, 1'b1, 4'd7);
        // Pad counts of eight and above decode no bit at all.
        send_decode(8'hB4, 1'b1, 4'd8);
        send_decode(8'hB4, 1'b1, 4'd15);
        // Pad bits on a byte that is not final are ignored.
        send_decode(8'h80, 1'b0, 4'd5);
        // Leave the walk on an inner node, then insert while the walk is pending.
        send_decode(8'h01, 1'b0, 4'd0);
        // This path runs through the leaf for symbol 00, so it hangs below a leaf.
        send_insert(8'h33, 6'd3, 32'h3);
        // The walk resumes from the inner node; eight results, the most one byte gives.
        send_decode(8'h00, 1'b0, 4'd0);
        // A code that ends on an inner node turns that node into a leaf.
        send_insert(8'h77, 6'd1, 32'h1);
        send_decode(8'hC0, 1'b1, 4'd6);
        // The unused action is ignored and yields no result.
        send_item(ACT_NONE, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'hF);
        // Longest usable code, then codes longer than the code path: only the
        // leading bits count, and bits above bit 31 read as zero.
        send_insert(8'h12, 6'(MAX_CODE_BITS), 32'hFFFF_FFFF);
        send_insert(8'h34, 6'd63, 32'h8000_0000 | $urandom);
        send_insert(8'h56, 6'd33, 32'h8000_0001);
        send_decode(8'h3C, 1'b1, 4'd2);
        // Clearing returns everything to the bare root.
        send_clear();
        send_decode(8'hFF, 1'b1, 4'd3);
        wait_for_results();

        // Random part: mostly well-formed code sets and streams, with store fills and
        // noise mixed in. The sender's idle plan changes every few dozen items, each
        // change preceded by a full drain of the expected results.
        items_sent = 0;
        phase      = 0;
        idle_pct   = IDLE_PLAN[0];
        while (items_sent < RANDOM_ITEMS) begin
            if (phase < 3 && items_sent >= (phase + 1) * PHASE_ITEMS) begin
                phase++;
                wait_for_results();
                idle_pct = IDLE_PLAN[phase];
            end
            pick = $urandom_range(99);
            if (pick < 70)
                run_code_stream();
            else if (pick < 80)
                run_store_fill();
            else
                run_noise();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
